/* design/slxd_pkg.sv */
// ----------------------------------------------------------------------------
// slxd_pkg: shared constants and types for the sync/length/XOR deframer
// Window geometry, sync bytes and the front-to-back command record.
// ----------------------------------------------------------------------------
package slxd_pkg;

  localparam int unsigned WinDepth = 64;
  localparam int unsigned WinAw    = $clog2(WinDepth);
  localparam int unsigned WinCw    = WinAw + 1;
  localparam int unsigned MaxData  = 59;
  localparam logic [7:0]  Sync0    = 8'hAA;
  localparam logic [7:0]  Sync1    = 8'h14;

  // One entry of the front-to-back queue: a received byte.
  typedef struct packed {
    logic [7:0] data;
  } slxd_cmd_t;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw    = $clog2(QDepth);

endpackage

/* design/slxd_front.sv */
// ----------------------------------------------------------------------------
// slxd_front: input queue
// Accepts received bytes and holds them in a short queue for the scanner.
// ----------------------------------------------------------------------------
module slxd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          rx_byte_i,
  output logic                q_valid_o,
  input  logic                q_ready_i,
  output slxd_pkg::slxd_cmd_t q_cmd_o
);
  import slxd_pkg::*;

  slxd_cmd_t            mem_q [QDepth];
  logic [QAw-1:0]       wr_q, rd_q;
  logic [QAw:0]         cnt_q;
  logic                 push, pop;

  assign in_ready_o = (cnt_q != (QAw+1)'(QDepth)) ? 1'b1 : 1'b0;
  assign push       = in_valid_i & in_ready_o;
  assign q_valid_o  = (cnt_q != '0);
  assign pop        = q_valid_o & q_ready_i;
  assign q_cmd_o    = mem_q[rd_q];

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q].data <= rx_byte_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + QAw'(1);
      if (pop)  rd_q <= rd_q + QAw'(1);
      cnt_q <= cnt_q + (QAw+1)'(push) - (QAw+1)'(pop);
    end
  end

endmodule

/* design/slxd_back.sv */
// ----------------------------------------------------------------------------
// slxd_back: window scanner
// Stores bytes in the window memory, hunts for sync, checks the XOR sums
// over cycles and streams verified packets out.
// ----------------------------------------------------------------------------
module slxd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  output logic                q_ready_o,
  input  slxd_pkg::slxd_cmd_t q_cmd_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          pkt_byte_o,
  output logic                pkt_first_o,
  output logic                pkt_last_o
);
  import slxd_pkg::*;

  // Scanner states
  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StRd    = 3'd1;  // issue read of byte at offset
  localparam logic [2:0] StChk   = 3'd2;  // evaluate read byte
  localparam logic [2:0] StEmitR = 3'd3;  // issue read for output
  localparam logic [2:0] StEmitW = 3'd4;  // load output register

  logic [7:0]        win_q [WinDepth];
  logic [7:0]        rd_data_q;
  logic [WinAw-1:0]  rd_addr;
  logic              rd_en;

  logic [2:0]        st_q, st_d;
  logic [WinAw-1:0]  head_q, head_d;
  logic [WinCw-1:0]  count_q, count_d;
  logic [WinCw-1:0]  k_q, k_d;      // offset being examined
  logic [7:0]        len_q, len_d;
  logic [7:0]        c0_q, c0_d, c1_q, c1_d;
  logic [WinCw-1:0]  total;
  logic              ov_q, ov_d;
  logic [7:0]        ob_q, ob_d;
  logic              of_q, of_d, ol_q, ol_d;
  logic              wr_en;
  logic [WinAw-1:0]  wr_addr;

  assign total = WinCw'(len_q) + WinCw'(5);
  assign q_ready_o = (st_q == StIdle);
  assign wr_en = q_valid_i & q_ready_o;
  assign wr_addr = head_q + count_q[WinAw-1:0];
  assign rd_addr = head_q + k_q[WinAw-1:0];
  assign rd_en = (st_q == StRd) || (st_q == StEmitR);

  // Window memory, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) win_q[wr_addr] <= q_cmd_i.data;
    if (rd_en) rd_data_q <= win_q[rd_addr];
  end

  // Scan sequencer
  always_comb begin
    st_d = st_q; head_d = head_q; count_d = count_q; k_d = k_q;
    len_d = len_q; c0_d = c0_q; c1_d = c1_q;
    ov_d = ov_q; ob_d = ob_q; of_d = of_q; ol_d = ol_q;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    unique case (st_q)
      StIdle: begin
        if (wr_en) begin
          count_d = count_q + WinCw'(1);
          k_d = '0;
          st_d = StRd;
        end
      end
      StRd: begin
        // wait for enough bytes, else read offset k
        if (k_q >= count_q) st_d = StIdle;
        else st_d = StChk;
      end
      StChk: begin
        st_d = StRd;
        k_d = k_q + WinCw'(1);
        if (k_q == WinCw'(0)) begin
          c0_d = rd_data_q; c1_d = '0;
          if (rd_data_q != Sync0) begin
            head_d = head_q + WinAw'(1); count_d = count_q - WinCw'(1);
            k_d = '0;
          end
        end else if (k_q == WinCw'(1)) begin
          c1_d = rd_data_q;
          if (rd_data_q != Sync1) begin
            head_d = head_q + WinAw'(1); count_d = count_q - WinCw'(1);
            k_d = '0;
          end
        end else if (k_q == WinCw'(2)) begin
          len_d = rd_data_q;
          c0_d = c0_q ^ rd_data_q;
          if (rd_data_q > 8'(MaxData)) begin
            head_d = head_q + WinAw'(1); count_d = count_q - WinCw'(1);
            k_d = '0;
          end else if (count_q < WinCw'(rd_data_q) + WinCw'(5)) begin
            // packet not complete yet: wait for more bytes
            st_d = StIdle;
          end
        end else if (k_q < WinCw'(len_q) + WinCw'(3)) begin
          if (k_q[0]) c1_d = c1_q ^ rd_data_q;
          else c0_d = c0_q ^ rd_data_q;
        end else if (k_q == WinCw'(len_q) + WinCw'(3)) begin
          if (rd_data_q != c0_q) begin
            head_d = head_q + WinAw'(1); count_d = count_q - WinCw'(1);
            k_d = '0;
          end
        end else begin
          if (rd_data_q != c1_q) begin
            head_d = head_q + WinAw'(1); count_d = count_q - WinCw'(1);
          end else begin
            st_d = StEmitR;
          end
          k_d = '0;
        end
      end
      StEmitR: begin
        if (!ov_q || out_ready_i) st_d = StEmitW;
        else k_d = k_q;
      end
      StEmitW: begin
        ov_d = 1'b1; ob_d = rd_data_q;
        of_d = (k_q == WinCw'(0));
        ol_d = (k_q + WinCw'(1) == total);
        if (ol_d) begin
          head_d = head_q + total[WinAw-1:0];
          count_d = count_q - total;
          k_d = '0;
          st_d = StRd;
        end else begin
          k_d = k_q + WinCw'(1);
          st_d = StEmitR;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; head_q <= '0; count_q <= '0; k_q <= '0;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d; head_q <= head_d; count_q <= count_d; k_q <= k_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q <= len_d; c0_q <= c0_d; c1_q <= c1_d;
    ob_q <= ob_d; of_q <= of_d; ol_q <= ol_d;
  end

  assign out_valid_o = ov_q;
  assign pkt_byte_o  = ob_q;
  assign pkt_first_o = of_q;
  assign pkt_last_o  = ol_q;

endmodule

/* design/sync_length_xor_packet_deframer.sv */
// The queue storage holds each byte until the scanner is idle; each window
// byte examined takes a memory read and a check, each emitted byte a read and
// an output load. A byte that only extends a partial packet costs an idle
// state and three header reads; one window memory read port sets the rate.
// Reset: rst_ni clears the queue, window head and count; window data is not
// cleared.
// ----------------------------------------------------------------------------
// sync_length_xor_packet_deframer: top level
// Front queue of received bytes feeding the window scanner.
// ----------------------------------------------------------------------------
module sync_length_xor_packet_deframer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] pkt_byte_o,
  output logic       pkt_first_o,
  output logic       pkt_last_o
);
  import slxd_pkg::*;

  logic      q_valid, q_ready;
  slxd_cmd_t q_cmd;

  slxd_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .rx_byte_i,
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_cmd_o(q_cmd)
  );

  slxd_back u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_ready_o(q_ready), .q_cmd_i(q_cmd),
    .out_valid_o, .out_ready_i, .pkt_byte_o, .pkt_first_o, .pkt_last_o
  );

endmodule

/* design/slxd_checker.sv */
// ----------------------------------------------------------------------------
// slxd_checker: port-level checks
// Watches the output stream of the deframer for framing slips.
// ----------------------------------------------------------------------------
module slxd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] pkt_byte_o,
  input logic       pkt_first_o,
  input logic       pkt_last_o
);
  import slxd_pkg::*;

  // A packet starts with the first sync byte
  a_first_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pkt_first_o |-> pkt_byte_o == Sync0) else $error("first not sync");

  // First and last never on the same item
  a_not_both: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(pkt_first_o && pkt_last_o)) else $error("first and last");

  // Any item shown right after a first item is the second sync byte
  a_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && pkt_first_o |=> !out_valid_o || pkt_byte_o == Sync1)
    else $error("second");

  // Stalled item holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pkt_byte_o))
    else $error("stall");

endmodule

bind sync_length_xor_packet_deframer slxd_checker u_slxd_checker (.*);

/* verif/tb_sync_length_xor_packet_deframer.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sync_length_xor_packet_deframer: self-checking bench for the deframer
// Feeds byte streams made of good packets, corrupted packets, false syncs and
// noise. A scoreboard model keeps its own byte window and predicts every
// emitted packet byte with its first/last flags.
// ----------------------------------------------------------------------------
module tb_sync_length_xor_packet_deframer;
  import slxd_pkg::*;

  localparam int unsigned IdleGuard = 20000;

  // Expected output byte with flags
  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
  } pkt_beat_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] rx_byte_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [7:0] pkt_byte_o;
  logic       pkt_first_o;
  logic       pkt_last_o;

  // Model state
  logic [7:0]   win_q [WinDepth];
  int unsigned  win_head;
  int unsigned  win_cnt;
  pkt_beat_t    beats_due [$];

  int unsigned  err_cnt;
  int unsigned  bytes_sent;
  int unsigned  beats_seen;
  int unsigned  pkts_seen;
  int unsigned  quiet_cycles = 0;
  bit           rx_hold;
  bit           rx_no_idle;
  bit           tx_no_idle;

  sync_length_xor_packet_deframer u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .rx_byte_i  (rx_byte_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .pkt_byte_o (pkt_byte_o),
    .pkt_first_o(pkt_first_o),
    .pkt_last_o (pkt_last_o)
  );

  // Clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic logic [7:0] win_at(int unsigned k);
    return win_q[(win_head + k) % WinDepth];
  endfunction

  function automatic void win_drop(int unsigned k);
    win_head = (win_head + k) % WinDepth;
    win_cnt  = win_cnt - k;
  endfunction

  // Append one byte to the window and rescan, queueing any verified packets
  function automatic void deframe_byte(logic [7:0] b);
    int unsigned len, total;
    logic [7:0]  c0, c1;
    pkt_beat_t   beat;
    if (win_cnt >= WinDepth) win_drop(1);
    win_q[(win_head + win_cnt) % WinDepth] = b;
    win_cnt++;
    forever begin
      while (win_cnt > 0 && win_at(0) != Sync0) win_drop(1);
      if (win_cnt < 2) break;
      if (win_at(1) != Sync1) begin
        win_drop(1);
        continue;
      end
      if (win_cnt < 3) break;
      len   = win_at(2);
      total = len + 5;
      if (len > MaxData || total > WinDepth) begin
        win_drop(1);
        continue;
      end
      if (win_cnt < total) break;
      c0 = '0;
      c1 = '0;
      for (int unsigned k = 0; k < len + 3; k++) begin
        if (k[0]) c1 ^= win_at(k);
        else c0 ^= win_at(k);
      end
      if (c0 != win_at(len + 3) || c1 != win_at(len + 4)) begin
        win_drop(1);
        continue;
      end
      for (int unsigned k = 0; k < total; k++) begin
        beat.data  = win_at(k);
        beat.first = (k == 0);
        beat.last  = (k + 1 == total);
        beats_due = {beats_due, beat};
      end
      win_drop(total);
    end
  endfunction

  // Send one byte; valid stays up until accepted
  task automatic send_byte(logic [7:0] b);
    while (!tx_no_idle && $urandom_range(99) < 7) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    deframe_byte(b);
    bytes_sent++;
  endtask

  task automatic send_idle();
    in_valid_i <= 1'b0;
  endtask

  // Send a full packet; corrupt flips a checksum bit
  task automatic send_packet(int unsigned len, bit corrupt);
    logic [7:0] body [$];
    logic [7:0] c0, c1;
    body = {Sync0, Sync1, 8'(len)};
    for (int unsigned k = 0; k < len; k++) body = {body, 8'($urandom)};
    c0 = '0;
    c1 = '0;
    foreach (body[k]) begin
      if (k % 2) c1 ^= body[k];
      else c0 ^= body[k];
    end
    if (corrupt) begin
      if ($urandom_range(1)) c0 ^= 8'(1 << $urandom_range(7));
      else c1 ^= 8'(1 << $urandom_range(7));
    end
    body = {body, c0, c1};
    foreach (body[k]) send_byte(body[k]);
  endtask

  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(8);
    if (r < 90) return $urandom_range(MaxData);
    return MaxData - $urandom_range(2);
  endfunction

  // Result checker
  always @(posedge clk_i) begin
    pkt_beat_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      beats_seen++;
      if (beats_due.size() == 0) begin
        $display("%0t: unexpected byte %h first %b last %b", $time,
                 pkt_byte_o, pkt_first_o, pkt_last_o);
        err_cnt++;
      end else begin
        want = beats_due[0];
        beats_due.delete(0);
        if (want.last) pkts_seen++;
        if (pkt_byte_o !== want.data) begin
          $display("%0t: pkt_byte expected %h actual %h", $time, want.data,
                   pkt_byte_o);
          err_cnt++;
        end
        if (pkt_first_o !== want.first) begin
          $display("%0t: pkt_first expected %b actual %b", $time, want.first,
                   pkt_first_o);
          err_cnt++;
        end
        if (pkt_last_o !== want.last) begin
          $display("%0t: pkt_last expected %b actual %b", $time, want.last,
                   pkt_last_o);
          err_cnt++;
        end
      end
    end
  end

  // Receiver ready: random stalls, or a long hold-off on request
  always @(posedge clk_i) begin
    if (!rst_ni) out_ready_i <= 1'b0;
    else if (rx_hold) out_ready_i <= 1'b0;
    else out_ready_i <= rx_no_idle || ($urandom_range(99) >= 7);
  end

  // Watchdog on lack of progress
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || rx_hold)
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IdleGuard) begin
      $display("sync_length_xor_packet_deframer verification failed");
      $finish;
    end
  end

  // Byte extremes, exact sync, max and min length
  task automatic test_directed();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(Sync0);
    send_byte(Sync0);
    send_byte(8'h55);
    send_packet(0, 0);
    send_packet(MaxData, 0);
    send_packet(3, 1);
  endtask

  // Length above the limit is a false sync; a good packet follows inside it
  task automatic test_false_sync();
    send_byte(Sync0);
    send_byte(Sync1);
    send_byte(8'(MaxData + 1));
    send_packet(2, 0);
    send_byte(Sync0);
    send_byte(Sync1);
    send_byte(8'hFF);
    send_packet(1, 0);
  endtask

  // Lone trailing sync byte then completion
  task automatic test_trailing_sync();
    send_byte(Sync0);
    send_idle();
    repeat (50) @(posedge clk_i);
    send_byte(Sync1);
    send_byte(8'h01);
    send_byte(8'h7E);
    send_byte(Sync0 ^ 8'h01);
    send_byte(Sync1 ^ 8'h7E);
  endtask

  // Long receiver hold-off while packets keep coming
  task automatic test_backpressure();
    rx_hold = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk_i);
        rx_hold = 1'b0;
      end
      repeat (12) send_packet($urandom_range(6), 0);
    join
  endtask

  // Mixed random stream: mostly good packets, some corrupt, noise
  task automatic test_random(int unsigned n_bytes);
    int unsigned r;
    while (bytes_sent < n_bytes) begin
      r = $urandom_range(99);
      if (r < 60) send_packet(pick_len(), 0);
      else if (r < 75) send_packet(pick_len(), 1);
      else if (r < 85) begin
        send_byte(Sync0);
        send_byte(Sync1);
        send_byte(8'($urandom));
      end else send_byte(8'($urandom));
    end
  endtask

  // Stretch with no idling on either side
  task automatic test_streaming();
    tx_no_idle = 1'b1;
    rx_no_idle = 1'b1;
    repeat (10) send_packet($urandom_range(10), $urandom_range(3) == 0);
    tx_no_idle = 1'b0;
    rx_no_idle = 1'b0;
  endtask

  initial begin
    int unsigned drain;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    rx_byte_i   = '0;
    out_ready_i = 1'b0;
    rx_hold     = 1'b0;
    rx_no_idle  = 1'b0;
    tx_no_idle  = 1'b0;
    err_cnt     = 0;
    bytes_sent  = 0;
    beats_seen  = 0;
    pkts_seen   = 0;
    win_head    = 0;
    win_cnt     = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_false_sync();
    test_trailing_sync();
    test_backpressure();
    test_streaming();
    test_random(450);
    send_idle();

    // Drain, then allow time for any stray output
    drain = 0;
    while (beats_due.size() != 0 && drain < 100000) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (400) @(posedge clk_i);
    if (beats_due.size() != 0) begin
      $display("%0t: %0d expected bytes never emitted", $time, beats_due.size());
      err_cnt++;
    end

    $display("Sent %0d bytes; checked %0d output bytes in %0d packets.",
             bytes_sent, beats_seen, pkts_seen);
    if (err_cnt == 0) begin
      $display("sync_length_xor_packet_deframer verification clean");
    end else begin
      $display("sync_length_xor_packet_deframer verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
design/slxd_pkg.sv
design/slxd_front.sv
design/slxd_back.sv
design/sync_length_xor_packet_deframer.sv
design/slxd_checker.sv
verif/tb_sync_length_xor_packet_deframer.sv
